### hw/rtl/ktm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktm_pkg
// Shared types and constants of the timestamp merge: item layouts, codes and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ktm_pkg;

  localparam int unsigned SOURCES_DEF     = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned MAX_RESULTS     = 64;

  localparam int unsigned CFG_W     = 4;
  localparam int unsigned SRC_FLD_W = 3;
  localparam int unsigned TS_W      = 64;
  localparam int unsigned PL_W      = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLOSE = 1'b1
  } ktm_op_e;

  typedef enum logic [1:0] {
    ST_RECORD = 2'd0,
    ST_FULL   = 2'd1,
    ST_BAD    = 2'd2
  } ktm_status_e;

  typedef struct packed {
    ktm_op_e              operation;
    logic [SRC_FLD_W-1:0] source;
    logic [TS_W-1:0]      timestamp;
    logic [PL_W-1:0]      payload;
  } ktm_in_item_t;

  typedef struct packed {
    ktm_status_e          status;
    logic [SRC_FLD_W-1:0] source_res;
    logic [TS_W-1:0]      timestamp_res;
    logic [PL_W-1:0]      payload_res;
    logic                 last;
  } ktm_out_item_t;

  typedef struct packed {
    logic take;
    logic decide;
    logic scan_start;
    logic pop;
    logic load_out;
    logic last;
  } ktm_cmd_t;

  typedef struct packed {
    logic err;
    logic have_pend;
    logic ready_more;
    logic scan_done;
    logic out_free;
  } ktm_sts_t;

endpackage
`default_nettype wire

### hw/rtl/ktm_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktm_stream_if
// Valid/ready channel carrying one item of type T per handshake.
// ----------------------------------------------------------------------------
interface ktm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/ktm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/ktm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktm_ctrl
// Sequencer: takes an item, checks it and either emits an error result or applies it,
// then runs the head scan, pop and emit loop until no further record may leave.
// ----------------------------------------------------------------------------
module ktm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ktm_pkg::ktm_sts_t sts_i,
  output ktm_pkg::ktm_cmd_t      cmd_o
);
  import ktm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CHECK,
    S_SCAN,
    S_POP,
    S_EMIT
  } state_e;

  state_e   state_q, state_d;
  logic     more_q, more_d;
  ktm_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    more_d  = more_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.take = 1'b1;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts_i.err) begin
          more_d  = 1'b0;
          state_d = S_EMIT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // a popped record waits in the datapath until we know if more follow
        if (sts_i.have_pend) begin
          more_d  = sts_i.ready_more;
          state_d = S_EMIT;
        end else if (sts_i.ready_more) begin
          cmd.scan_start = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        state_d = S_CHECK;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = !more_q;
          if (more_q) begin
            cmd.scan_start = 1'b1;
            state_d        = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      more_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

endmodule
`default_nettype wire

### hw/rtl/ktm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ktm_dpath
// Per-source queues (one shared RAM plus fill/head/closed registers), the
// head scan with its running minimum, and the output register.
// ----------------------------------------------------------------------------
module ktm_dpath #(
  parameter int unsigned SOURCES     = ktm_pkg::SOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH = ktm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ktm_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire ktm_pkg::ktm_in_item_t        in_item_i,
  input  wire ktm_pkg::ktm_cmd_t            cmd_i,
  output ktm_pkg::ktm_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output ktm_pkg::ktm_out_item_t            out_item_o
);
  import ktm_pkg::*;

  localparam int unsigned SRC_W  = $clog2(SOURCES);
  localparam int unsigned USE_W  = $clog2(SOURCES + 1);
  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W = SRC_W + SLOT_W;
  localparam int unsigned DEPTH  = SOURCES * (2 ** SLOT_W);
  localparam int unsigned WORD_W = TS_W + PL_W;
  localparam int unsigned N_W    = $clog2(MAX_RESULTS + 1);

  // control state
  logic [CFG_W-1:0]  cfg_q;
  logic [FILL_W-1:0] fill_q [SOURCES];
  logic [FILL_W-1:0] fill_d [SOURCES];
  logic [SLOT_W-1:0] head_q [SOURCES];
  logic [SLOT_W-1:0] head_d [SOURCES];
  logic [SOURCES-1:0] closed_q, closed_d;
  logic [N_W-1:0]    n_q;
  logic              issuing_q, cmp_vld_q, found_q, out_valid_q;
  logic [SRC_W-1:0]  scan_idx_q;
  ktm_status_e       pend_status_q;

  // payload
  ktm_in_item_t      in_q;
  logic [SRC_W-1:0]  cmp_src_q, best_src_q;
  logic              cmp_has_q;
  logic [TS_W-1:0]   best_ts_q;
  logic [PL_W-1:0]   best_pl_q;
  ktm_out_item_t     out_item_q;

  logic [USE_W-1:0]  used;
  logic              src_ok, err_bad, err_full, is_push;
  logic [SRC_W-1:0]  sel;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic              ram_we;
  logic [WORD_W-1:0] rd_word;
  logic [TS_W-1:0]   rd_ts;
  logic [PL_W-1:0]   rd_pl;
  logic              scan_last, take_best, all_ok, any_rec, out_free;

  always_comb begin
    if (cfg_q == '0) begin
      used = USE_W'(1);
    end else if (32'(cfg_q) > SOURCES) begin
      used = USE_W'(SOURCES);
    end else begin
      used = USE_W'(cfg_q);
    end
  end

  // one index into the per-source registers, chosen by phase
  always_comb begin
    if (issuing_q) begin
      sel = scan_idx_q;
    end else if (cmd_i.pop) begin
      sel = best_src_q;
    end else begin
      sel = SRC_W'(in_q.source);
    end
  end

  assign src_ok   = 32'(in_q.source) < 32'(used);
  assign is_push  = (in_q.operation == OP_PUSH);
  assign err_bad  = !src_ok || closed_q[sel];
  assign err_full = is_push && (32'(fill_q[sel]) == QUEUE_DEPTH);

  // tail slot: head plus fill, wrapped once
  always_comb begin
    slot_sum = (SLOT_W + 1)'(head_q[sel]) + (SLOT_W + 1)'(fill_q[sel]);
    if (slot_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - (SLOT_W + 1)'(QUEUE_DEPTH);
    end
    wr_slot = slot_sum[SLOT_W-1:0];
  end

  assign ram_we = cmd_i.decide && !err_bad && !err_full && is_push;

  ktm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({sel, wr_slot}),
    .wdata_i ({in_q.timestamp, in_q.payload}),
    .raddr_i ({sel, head_q[sel]}),
    .rdata_o (rd_word)
  );

  assign rd_ts     = rd_word[WORD_W-1:PL_W];
  assign rd_pl     = rd_word[PL_W-1:0];
  assign scan_last = (32'(scan_idx_q) + 32'd1) == 32'(used);
  // strict compare in ascending source order keeps ties on the lowest index
  assign take_best = cmp_vld_q && cmp_has_q && (!found_q || (rd_ts < best_ts_q));

  always_comb begin
    all_ok  = 1'b1;
    any_rec = 1'b0;
    for (int s = 0; s < SOURCES; s++) begin
      if (s < int'(used)) begin
        if (fill_q[s] != '0) begin
          any_rec = 1'b1;
        end else if (!closed_q[s]) begin
          all_ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    fill_d   = fill_q;
    head_d   = head_q;
    closed_d = closed_q;
    if (cmd_i.decide && !err_bad && !err_full) begin
      if (is_push) begin
        fill_d[sel] = fill_q[sel] + FILL_W'(1);
      end else begin
        closed_d[sel] = 1'b1;
      end
    end
    if (cmd_i.pop) begin
      fill_d[sel] = fill_q[sel] - FILL_W'(1);
      if (32'(head_q[sel]) == QUEUE_DEPTH - 1) begin
        head_d[sel] = '0;
      end else begin
        head_d[sel] = head_q[sel] + SLOT_W'(1);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q         <= CFG_RESET;
      fill_q        <= '{default: '0};
      head_q        <= '{default: '0};
      closed_q      <= '0;
      n_q           <= '0;
      issuing_q     <= 1'b0;
      cmp_vld_q     <= 1'b0;
      found_q       <= 1'b0;
      scan_idx_q    <= '0;
      pend_status_q <= ST_RECORD;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      fill_q    <= fill_d;
      head_q    <= head_d;
      closed_q  <= closed_d;
      cmp_vld_q <= issuing_q;
      if (cmd_i.decide) begin
        n_q <= '0;
        if (err_bad) begin
          pend_status_q <= ST_BAD;
        end else if (err_full) begin
          pend_status_q <= ST_FULL;
        end
      end
      if (cmd_i.pop) begin
        n_q <= n_q + N_W'(1);
      end
      if (cmd_i.scan_start) begin
        issuing_q     <= 1'b1;
        scan_idx_q    <= '0;
        found_q       <= 1'b0;
        pend_status_q <= ST_RECORD;
      end else if (issuing_q) begin
        if (scan_last) begin
          issuing_q <= 1'b0;
        end else begin
          scan_idx_q <= scan_idx_q + SRC_W'(1);
        end
      end
      if (take_best) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      in_q <= in_item_i;
    end
    if (issuing_q) begin
      cmp_src_q <= scan_idx_q;
      cmp_has_q <= (fill_q[sel] != '0);
    end
    if (take_best) begin
      best_src_q <= cmp_src_q;
      best_ts_q  <= rd_ts;
      best_pl_q  <= rd_pl;
    end
    if (cmd_i.load_out) begin
      out_item_q.status <= pend_status_q;
      out_item_q.last   <= cmd_i.last;
      if (pend_status_q == ST_RECORD) begin
        out_item_q.source_res    <= SRC_FLD_W'(best_src_q);
        out_item_q.timestamp_res <= best_ts_q;
        out_item_q.payload_res   <= best_pl_q;
      end else begin
        out_item_q.source_res    <= in_q.source;
        out_item_q.timestamp_res <= '0;
        out_item_q.payload_res   <= '0;
      end
    end
  end

  assign sts_o.err        = err_bad || err_full;
  assign sts_o.have_pend  = (n_q != '0);
  assign sts_o.ready_more = all_ok && any_rec && (n_q < N_W'(MAX_RESULTS));
  assign sts_o.scan_done  = cmp_vld_q && !issuing_q;
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

### hw/rtl/k_way_timestamp_merge.sv
`default_nettype none
// An error result is loaded into the output register from the emit state, straight after
// the decide state; an item that releases nothing returns to idle after the check state.
// Each emitted record needs a scan of the heads of all used sources, used being the
// effective source count: one source a cycle through the single RAM read port.
// Reset: all queues empty, all sources open, sources_in_use = 8; the record RAM is not
// cleared (only written entries are ever used), so there is no clearing pass.
// ----------------------------------------------------------------------------
// k_way_timestamp_merge
// Merges per-source timestamp-ordered record queues into one ordered stream.
// ----------------------------------------------------------------------------
module k_way_timestamp_merge #(
  parameter int unsigned SOURCES     = ktm_pkg::SOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH = ktm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ktm_pkg::CFG_W-1:0] cfg_wdata_i,
  ktm_stream_if.sink                     in_i,
  ktm_stream_if.source                   out_o
);
  import ktm_pkg::*;

  ktm_cmd_t cmd;
  ktm_sts_t sts;

  ktm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ktm_dpath #(
    .SOURCES     (SOURCES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_o.data)
  );

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take, cmd.decide, cmd.pop}))
    else $error("take, decide and pop overlap");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("output register loaded while still full");

  a_take_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken before the first was checked");

  a_pop_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> $past(sts.scan_done))
    else $error("pop without a finished head scan");

endmodule
`default_nettype wire
